>>> rtl/core/voice_resampling_mixer_top_defines.svh
// Assertion macros for the voice resampling mixer.
// Used by the files that carry concurrent checks.
`ifndef VOICE_RESAMPLING_MIXER_TOP_DEFINES_SVH
`define VOICE_RESAMPLING_MIXER_TOP_DEFINES_SVH
`ifndef SYNTH
`define VRM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VRM_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VRM_ASSERT(label, clk, rst_n, prop, msg)
`define VRM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/vrm_pkg.sv
// Shared types and constants for the voice resampling mixer.
// No dependencies.
`timescale 1ns / 1ps
package vrm_pkg;
	localparam int SAMPLE_DEPTH     = 16384;
	localparam int MAX_BUFFER_BYTES = 4096;
	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int BBW = $clog2(MAX_BUFFER_BYTES) + 1;
	localparam int FW  = BBW - 1;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_MIX   = 2'd3;

	localparam logic [1:0] MODE_STEREO = 2'd0;
	localparam logic [1:0] MODE_M2S    = 2'd1;
	localparam logic [1:0] MODE_MONO   = 2'd2;
	localparam logic [1:0] MODE_SILENT = 2'd3;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_GL   = 3'd1;
	localparam logic [2:0] REG_GR   = 3'd2;
	localparam logic [2:0] REG_STEP = 3'd3;
	localparam logic [2:0] REG_LEN  = 3'd4;
	localparam logic [2:0] REG_BUF  = 3'd5;

	typedef struct packed {
		logic [1:0]  op;
		logic [13:0] sample_addr;
		logic signed [15:0] sample_word;
		logic signed [15:0] dest_left;
		logic signed [15:0] dest_right;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] mixed_left;
		logic signed [15:0] mixed_right;
		logic voice_playing;
		logic buffer_end;
	} out_beat_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  gain_left;
		logic [7:0]  gain_right;
		logic [15:0] step;
		logic [15:0] len;
		logic [12:0] buf_bytes;
	} cfg_t;

	function automatic logic [15:0] scale(input logic signed [15:0] s, input logic [7:0] g);
		logic signed [24:0] p;
		p = s * $signed({1'b0, g});
		return p[23:8];
	endfunction
endpackage

>>> rtl/core/vrm_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing but the payload type parameter.
`timescale 1ns / 1ps
interface vrm_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/vrm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vrm_ram #(parameter int WIDTH = 16, parameter int DEPTH = 256) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

>>> rtl/core/vrm_divider.sv
// Restoring divider, one quotient bit a cycle (frames left by step).
// No dependencies.
`timescale 1ns / 1ps
module vrm_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [23:0] num,
	input  logic [15:0] den,
	output logic busy,
	output logic [23:0] quo
);
	logic [4:0]  cnt_q;
	logic [23:0] n_q;
	logic [16:0] r_q;
	logic [16:0] trial;
	assign trial = {r_q[15:0], n_q[23]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd24;
		end else if (cnt_q != 0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
		end else if (cnt_q != 0) begin
			if (trial >= {1'b0, den}) begin
				r_q <= trial - {1'b0, den};
				n_q <= {n_q[22:0], 1'b1};
			end else begin
				r_q <= trial;
				n_q <= {n_q[22:0], 1'b0};
			end
		end
	end
	assign busy = (cnt_q != 0);
	assign quo  = n_q;
endmodule

>>> rtl/core/vrm_front.sv
// Front end: accepts beats into a two-entry queue for the back end.
// Uses vrm_pkg and vrm_if.
`timescale 1ns / 1ps
module vrm_front (
	input  logic clk,
	input  logic arst_n,
	vrm_if.sink   in_ch,
	input  logic  pop,
	output logic  has,
	output vrm_pkg::in_beat_t head
);
	import vrm_pkg::*;
	`include "voice_resampling_mixer_top_defines.svh"
	in_beat_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;
	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign has  = (cnt_q != 0);
	assign head = q_q[rd_q];
	always_ff @(posedge clk) if (push) q_q[wr_q] <= in_ch.data;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
	`VRM_ASSERT(a_no_pop_empty, clk, arst_n, pop |-> has, "pop from empty queue")
	`VRM_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= 2'd2, "queue count overflow")
	`VRM_ASSERT(a_full_stall, clk, arst_n, (cnt_q == 2'd2) |-> !in_ch.ready, "accept when full")
endmodule

>>> rtl/core/vrm_back.sv
// Back end: plans each buffer, reads samples, mixes and drives the result register.
// Uses vrm_pkg, vrm_if, vrm_ram and vrm_divider.
`timescale 1ns / 1ps
module vrm_back (
	input  logic clk,
	input  logic arst_n,
	input  vrm_pkg::cfg_t cfg,
	input  logic has,
	input  vrm_pkg::in_beat_t head,
	output logic pop,
	vrm_if.source out_ch
);
	import vrm_pkg::*;
	`include "voice_resampling_mixer_top_defines.svh"

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_PLAN  = 7'b0000010,
		S_DIV   = 7'b0000100,
		S_RD0   = 7'b0001000,
		S_RD1   = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} st_t;
	st_t st_q;

	logic [15:0] pos_q;
	logic        active_q, stop_q;
	logic [FW-1:0] fidx_q;
	logic [FW:0]   ftm_q;
	logic [27:0]   cur_q;
	logic signed [15:0] sl_q;
	out_beat_t     res_q;
	logic          res_v_q;

	// effective buffer parameters
	logic [12:0] bb;
	logic [FW:0] fpb;
	logic [15:0] stepv;
	assign bb = (cfg.buf_bytes > 13'(MAX_BUFFER_BYTES)) ? 13'(MAX_BUFFER_BYTES) : cfg.buf_bytes;
	always_comb begin
		fpb = (cfg.mode == MODE_MONO) ? (FW+1)'(bb >> 1) : (FW+1)'(bb >> 2);
		if (fpb == 0) fpb = (FW+1)'(1);
	end
	assign stepv = (cfg.step == 0) ? 16'd1 : cfg.step;

	// plan arithmetic
	logic [16:0] rem;
	logic [28:0] prod;
	logic [21:0] nxt;
	logic [23:0] num;
	assign rem  = (cfg.len > pos_q) ? {1'b0, cfg.len} - {1'b0, pos_q} : 17'd0;
	assign prod = fpb * stepv;
	assign nxt  = {6'd0, pos_q} + ((cfg.mode == MODE_STEREO) ? {1'b0, prod[28:8]} << 2
		: {1'b0, prod[28:8]} << 1);
	assign num  = (cfg.mode == MODE_STEREO) ? {rem[15:0], 8'd0} >> 2 : {rem[15:0], 8'd0} >> 1;

	logic div_start, div_busy, plan_div;
	logic [23:0] quo;
	vrm_divider u_div (.clk, .arst_n, .start(div_start), .num, .den(stepv),
		.busy(div_busy), .quo);
	assign plan_div = (st_q == S_PLAN) && active_q && cfg.mode != MODE_SILENT &&
		cfg.mode != MODE_MONO && (nxt > {6'd0, cfg.len});

	// sample store
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0] ram_rd;
	logic [27:0] cur_m1;
	assign cur_m1 = cur_q + 28'd127;
	vrm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_ram (.clk, .we(ram_we), .addr(ram_addr),
		.wdata(head.sample_word), .rdata(ram_rd));

	logic is_mix, mixing, last;
	assign is_mix = has && head.op == OP_MIX;
	assign mixing = active_q && ({1'b0, fidx_q} < ftm_q) && cfg.mode != MODE_SILENT;
	assign last   = ({1'b0, fidx_q} + 1'b1) >= fpb;

	always_comb begin
		ram_we = 1'b0;
		ram_addr = cur_q[8 +: AW];
		if (st_q == S_IDLE && has && head.op == OP_LOAD) begin
			ram_we = 1'b1;
			ram_addr = head.sample_addr[AW-1:0];
		end else if (cfg.mode == MODE_M2S) begin
			ram_addr = cur_m1[8 +: AW];
		end
	end

	assign out_ch.valid = res_v_q;
	assign out_ch.data  = res_q;
	logic can_out;
	assign can_out = !res_v_q || out_ch.ready;
	assign pop = (st_q == S_IDLE && has && head.op != OP_MIX && can_out) ||
		(st_q == S_FIN && can_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; pos_q <= '0; active_q <= 1'b0; stop_q <= 1'b0;
			fidx_q <= '0; ftm_q <= '0; cur_q <= '0; res_v_q <= 1'b0;
			div_start <= 1'b0; sl_q <= '0; res_q <= '0;
		end else begin
			div_start <= plan_div;
			if (pop) res_v_q <= 1'b1;
			else if (out_ch.ready) res_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (has && !is_mix && can_out) begin
						res_q <= '{mixed_left: '0, mixed_right: '0,
							voice_playing: (head.op == OP_LOAD) ? active_q
								: (head.op == OP_START),
							buffer_end: 1'b0};
						if (head.op != OP_LOAD) begin
							active_q <= (head.op == OP_START);
							pos_q <= '0; ftm_q <= '0; stop_q <= 1'b0;
						end
					end else if (is_mix) begin
						st_q <= (fidx_q == 0) ? S_PLAN : S_RD0;
					end
				end
				S_PLAN: begin
					cur_q <= {5'd0, pos_q[15:1], 8'd0};
					if (!active_q || cfg.mode == MODE_SILENT) begin
						ftm_q <= '0;
						stop_q <= 1'b0;
						st_q <= S_RD0;
					end else if (cfg.mode == MODE_MONO) begin
						st_q <= S_RD0;
						if (cfg.len < pos_q || rem <= {4'd0, bb}) begin
							ftm_q <= ((rem >> 1) > 17'(fpb)) ? fpb : (FW+1)'(rem >> 1);
							stop_q <= 1'b1;
						end else begin
							ftm_q <= fpb;
							stop_q <= 1'b0;
							pos_q <= pos_q + {3'd0, bb};
						end
					end else if (nxt > {6'd0, cfg.len}) begin
						stop_q <= 1'b1;
						st_q <= S_DIV;
					end else begin
						ftm_q <= fpb;
						stop_q <= 1'b0;
						pos_q <= nxt[15:0];
						st_q <= S_RD0;
					end
				end
				S_DIV: begin
					if (!div_start && !div_busy) begin
						ftm_q <= (quo > 24'(fpb)) ? fpb : (FW+1)'(quo);
						st_q <= S_RD0;
					end
				end
				S_RD0: begin
					if (mixing && cfg.mode == MODE_STEREO) cur_q <= cur_q + 28'(stepv);
					st_q <= S_RD1;
				end
				S_RD1: begin
					sl_q <= ram_rd;
					// stereo keeps the right-word address until the beat leaves
					if (mixing && cfg.mode == MODE_M2S) cur_q <= cur_q + 28'(stepv);
					else if (mixing && cfg.mode == MODE_MONO) cur_q <= cur_q + 28'd256;
					st_q <= S_FIN;
				end
				S_FIN: begin
					if (can_out) begin
						if (mixing && cfg.mode == MODE_STEREO) cur_q <= cur_q + 28'(stepv);
						res_q.mixed_left <= mixing ? head.dest_left + scale(sl_q, cfg.gain_left)
							: head.dest_left;
						if (cfg.mode == MODE_MONO) res_q.mixed_right <= '0;
						else if (!mixing) res_q.mixed_right <= head.dest_right;
						else if (cfg.mode == MODE_STEREO)
							res_q.mixed_right <= head.dest_right + scale(ram_rd, cfg.gain_right);
						else res_q.mixed_right <= head.dest_right + scale(sl_q, cfg.gain_right);
						res_q.buffer_end <= last;
						res_q.voice_playing <= (last && stop_q) ? 1'b0 : active_q;
						if (last) begin
							fidx_q <= '0;
							if (stop_q) begin
								active_q <= 1'b0; pos_q <= '0; stop_q <= 1'b0;
							end
						end else begin
							fidx_q <= fidx_q + 1'b1;
						end
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`VRM_ASSERT(a_fin_from_rd1, clk, arst_n, (st_q == S_FIN) |-> $past(st_q == S_RD1 || st_q == S_FIN), "bad finish")
	`VRM_ASSERT(a_div_stop, clk, arst_n, (st_q == S_DIV) |-> stop_q, "divide without stop")
	`VRM_ASSERT(a_pop_out, clk, arst_n, pop |=> res_v_q, "popped beat without result")
endmodule

>>> rtl/core/voice_resampling_mixer_top.sv
// Voice resampling mixer: one result beat per input beat, in order. A mix beat
// passes through the back-end sequencer (two sample-store reads on the single
// RAM port), and the first frame of a buffer adds the planning state, plus a
// bit-serial divide in stereo and mono-to-stereo modes when the voice would run
// past the sample end.
// Uses vrm_pkg, vrm_if, vrm_front and vrm_back.
`timescale 1ns / 1ps
module voice_resampling_mixer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	vrm_if.sink   in_ch,
	vrm_if.source out_ch
);
	import vrm_pkg::*;
	cfg_t cfg_q;
	logic has, pop;
	in_beat_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: MODE_SILENT, gain_left: '0, gain_right: '0, step: 16'd256,
				len: '0, buf_bytes: 13'd4096};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_data[1:0];
				REG_GL:   cfg_q.gain_left <= cfg_data[7:0];
				REG_GR:   cfg_q.gain_right <= cfg_data[7:0];
				REG_STEP: cfg_q.step <= cfg_data;
				REG_LEN:  cfg_q.len <= cfg_data;
				REG_BUF:  cfg_q.buf_bytes <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	vrm_front u_front (.clk, .arst_n, .in_ch, .pop, .has, .head);
	vrm_back  u_back (.clk, .arst_n, .cfg(cfg_q), .has, .head, .pop, .out_ch);
endmodule
